// File: design/pll_bus_clock_calculator_macros.svh
// assertion macros for the pll bus clock calculator
`ifndef PLL_BUS_CLOCK_CALCULATOR_MACROS_SVH
`define PLL_BUS_CLOCK_CALCULATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PBCC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold
`define PBCC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: design/pbcc_pkg.sv
// shared constants, types and helper functions of the pll bus clock calculator
`timescale 1ns / 1ps

package pbcc_pkg;

  localparam int unsigned CrystalW = 24;
  localparam int unsigned PllW     = 20;
  localparam int unsigned BusW     = 4;
  localparam int unsigned CamW     = 8;
  localparam int unsigned ClkW     = 32;

  localparam int unsigned MW    = 8;
  localparam int unsigned PW    = 6;
  localparam int unsigned SW    = 2;
  localparam int unsigned MLsb  = 12;
  localparam int unsigned PLsb  = 4;
  localparam int unsigned SLsb  = 0;
  localparam int unsigned MOfsW = 9;
  localparam int unsigned DenW  = 7;
  localparam int unsigned RemW  = 7;

  localparam logic [CrystalW-1:0] CrystalReset = 24'd12000000;
  localparam logic [MOfsW-1:0]    MOffset      = 9'd8;
  localparam logic [DenW-1:0]     POffset      = 7'd2;

  // crystal / 100 by reciprocal multiply
  localparam int unsigned   CqW         = 18;
  localparam int unsigned   MagicW      = 32;
  localparam logic [31:0]   Div100Magic = 32'h51EB851F;
  localparam int unsigned   Div100Shift = 37;
  localparam int unsigned   CqProdW     = CrystalW + MagicW;

  localparam int unsigned MainMcW  = MOfsW + CqW;
  localparam int unsigned MainNumW = MainMcW + 1;
  localparam int unsigned UsbNumW  = MOfsW + CrystalW;

  localparam int unsigned DivBitsPerStage = 4;
  localparam int unsigned DivStages       = 9;
  localparam int unsigned DivW            = DivBitsPerStage * DivStages;

  localparam int unsigned ScaleW   = 7;
  localparam logic [ScaleW-1:0] Scale100 = 7'd100;
  localparam int unsigned ScaleProdW = ClkW + ScaleW;

  // x / 3 by reciprocal multiply
  localparam logic [31:0] Div3Magic = 32'hAAAAAAAB;
  localparam int unsigned Div3Shift = 33;
  localparam int unsigned Div3ProdW = ClkW + MagicW;

  // select bits
  localparam int unsigned BusPclkHalfBit = 0;
  localparam int unsigned BusHclkLsb     = 1;
  localparam int unsigned BusUsbHalfBit  = 3;
  localparam int unsigned CamSixthBit    = 0;
  localparam int unsigned CamEighthBit   = 1;
  localparam int unsigned CamCpuHclkBit  = 4;

  typedef enum logic [1:0] {
    HclkDiv1 = 2'd0,
    HclkDiv2 = 2'd1,
    HclkDiv4 = 2'd2,
    HclkDiv3 = 2'd3
  } hclk_code_e;

  typedef struct packed {
    logic [MOfsW-1:0] m_ofs;
    logic [DenW-1:0]  den;
    logic [SW-1:0]    s;
  } pll_t;

  typedef struct packed {
    logic [BusW-1:0] bus;
    logic [CamW-1:0] cam;
  } sel_t;

  typedef struct packed {
    logic [DivW-1:0] acc;
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t main_lane;
    div_lane_t usb_lane;
    sel_t      sel;
  } div_t;

  typedef struct packed {
    logic [ClkW-1:0] core;
    logic [ClkW-1:0] bus;
    logic [ClkW-1:0] periph;
    logic [ClkW-1:0] cpu;
    logic [ClkW-1:0] usb;
  } clocks_t;

  function automatic pll_t split_pll(logic [PllW-1:0] word);
    pll_t r;
    r.m_ofs = MOfsW'(word[MLsb +: MW]) + MOffset;
    r.den   = DenW'(word[PLsb +: PW]) + POffset;
    r.s     = word[SLsb +: SW];
    return r;
  endfunction

  // restoring division, DivBitsPerStage (4) quotient bits per call
  function automatic div_lane_t div_steps(div_lane_t lane_in);
    div_lane_t       lane;
    logic [RemW:0]   sh;
    logic [RemW:0]   den_x;
    lane  = lane_in;
    den_x = {1'b0, lane_in.den};
    for (int i = 0; i < DivBitsPerStage; i++) begin
      sh       = {lane.rem, lane.acc[DivW-1]};
      lane.acc = {lane.acc[DivW-2:0], 1'b0};
      if (sh >= den_x) begin
        lane.rem    = RemW'(sh - den_x);
        lane.acc[0] = 1'b1;
      end else begin
        lane.rem = sh[RemW-1:0];
      end
    end
    return lane;
  endfunction

endpackage

// File: design/pbcc_intf.sv
// input and output channel interfaces of the pll bus clock calculator
`timescale 1ns / 1ps

interface pbcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pbcc_pkg::PllW-1:0]    main_pll_word;
  logic [pbcc_pkg::PllW-1:0]    usb_pll_word;
  logic [pbcc_pkg::BusW-1:0]    bus_divider_word;
  logic [pbcc_pkg::CamW-1:0]    camera_divider_high;

  modport source (
    output valid, main_pll_word, usb_pll_word, bus_divider_word, camera_divider_high,
    input  ready
  );
  modport sink (
    input  valid, main_pll_word, usb_pll_word, bus_divider_word, camera_divider_high,
    output ready
  );
endinterface

interface pbcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pbcc_pkg::ClkW-1:0]    core_clock_hz;
  logic [pbcc_pkg::ClkW-1:0]    bus_clock_hz;
  logic [pbcc_pkg::ClkW-1:0]    peripheral_clock_hz;
  logic [pbcc_pkg::ClkW-1:0]    cpu_clock_hz;
  logic [pbcc_pkg::ClkW-1:0]    usb_clock_hz;

  modport source (
    output valid, core_clock_hz, bus_clock_hz, peripheral_clock_hz, cpu_clock_hz,
           usb_clock_hz,
    input  ready
  );
  modport sink (
    input  valid, core_clock_hz, bus_clock_hz, peripheral_clock_hz, cpu_clock_hz,
           usb_clock_hz,
    output ready
  );
endinterface

// File: design/pll_bus_clock_calculator.sv
// top level of the pll bus clock calculator
//
// usage:
//   in_i takes one transaction per cycle while ready: the main and usb pll words,
//   the bus divider word and the upper camera divider byte. out_o returns one
//   transaction per input with the core, bus, peripheral, cpu and usb clocks in Hz.
//   cfg_we_i/cfg_data_i write the crystal frequency; write it only while idle.
//   throughput: one transaction per cycle, back to back unless out_o stalls.
//   a result passes 2 setup stages, the 36-bit restoring divider (9 stages of
//   4 quotient bits) and 3 scaling and select stages before it is valid on out_o.
//   every stage is a register with its own valid bit; a stalled receiver
//   fills the empty stages first, then ready on in_i drops.
//   reset clears all valid bits and loads 12 MHz as the crystal frequency;
//   there is no clearing pass, input is taken in the first cycle after reset.
//
`timescale 1ns / 1ps
`include "pll_bus_clock_calculator_macros.svh"

module pll_bus_clock_calculator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbcc_pkg::CrystalW-1:0]  cfg_data_i,
  pbcc_in_if.sink                        in_i,
  pbcc_out_if.source                     out_o
);

  logic [pbcc_pkg::CrystalW-1:0]   crystal_q;
  logic [pbcc_pkg::DivStages:0]    dv_valid, dv_ready;
  pbcc_pkg::div_t                  dv_data [pbcc_pkg::DivStages+1];
  logic                            res_valid;
  pbcc_pkg::clocks_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_q <= pbcc_pkg::CrystalReset;
    end else if (cfg_we_i) begin
      crystal_q <= cfg_data_i;
    end
  end

  pbcc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .crystal_i   (crystal_q),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .main_word_i (in_i.main_pll_word),
    .usb_word_i  (in_i.usb_pll_word),
    .bus_i       (in_i.bus_divider_word),
    .cam_i       (in_i.camera_divider_high),
    .valid_o     (dv_valid[0]),
    .ready_i     (dv_ready[0]),
    .data_o      (dv_data[0])
  );

  for (genvar k = 0; k < pbcc_pkg::DivStages; k++) begin : g_div
    pbcc_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .ready_o (dv_ready[k]),
      .data_i  (dv_data[k]),
      .valid_o (dv_valid[k+1]),
      .ready_i (dv_ready[k+1]),
      .data_o  (dv_data[k+1])
    );
  end

  pbcc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid[pbcc_pkg::DivStages]),
    .ready_o (dv_ready[pbcc_pkg::DivStages]),
    .data_i  (dv_data[pbcc_pkg::DivStages]),
    .valid_o (res_valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.valid               = res_valid;
  assign out_o.core_clock_hz       = res.core;
  assign out_o.bus_clock_hz        = res.bus;
  assign out_o.peripheral_clock_hz = res.periph;
  assign out_o.cpu_clock_hz        = res.cpu;
  assign out_o.usb_clock_hz        = res.usb;

  `PBCC_ASSERT_NEVER(a_pclk_le_hclk, out_o.valid && (out_o.peripheral_clock_hz > out_o.bus_clock_hz), "pclk above hclk")
  `PBCC_ASSERT_IMPLIES(a_hclk_le_fclk, out_o.valid, out_o.bus_clock_hz <= out_o.core_clock_hz, "hclk above fclk")
  `PBCC_ASSERT_IMPLIES(a_cpu_source, out_o.valid, (out_o.cpu_clock_hz == out_o.bus_clock_hz) || (out_o.cpu_clock_hz == out_o.core_clock_hz), "cpu clock from neither hclk nor fclk")

endmodule

// File: design/pbcc_prep.sv
// field split, crystal scaling and pll numerator stages
`timescale 1ns / 1ps

module pbcc_prep (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [pbcc_pkg::CrystalW-1:0]   crystal_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [pbcc_pkg::PllW-1:0]       main_word_i,
  input  logic [pbcc_pkg::PllW-1:0]       usb_word_i,
  input  logic [pbcc_pkg::BusW-1:0]       bus_i,
  input  logic [pbcc_pkg::CamW-1:0]       cam_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output pbcc_pkg::div_t                  data_o
);

  logic [pbcc_pkg::CqProdW-1:0]  cq_prod;
  logic                          s1_ready, s2_ready;
  logic                          s1_valid_q, s2_valid_q;
  logic [pbcc_pkg::CqW-1:0]      s1_cq_q;
  pbcc_pkg::pll_t                s1_main_q, s1_usb_q;
  pbcc_pkg::sel_t                s1_sel_q;
  logic [pbcc_pkg::MainMcW-1:0]  main_mc;
  logic [pbcc_pkg::MainNumW-1:0] main_num;
  logic [pbcc_pkg::UsbNumW-1:0]  usb_num;
  pbcc_pkg::div_t                s2_d, s2_q;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  assign cq_prod = pbcc_pkg::CqProdW'(crystal_i) * pbcc_pkg::CqProdW'(pbcc_pkg::Div100Magic);

  // numerators, pre-shifted by s so only p+2 is left to divide by
  assign main_mc  = pbcc_pkg::MainMcW'(s1_main_q.m_ofs) * pbcc_pkg::MainMcW'(s1_cq_q);
  assign main_num = {main_mc, 1'b0};
  assign usb_num  = pbcc_pkg::UsbNumW'(s1_usb_q.m_ofs) * pbcc_pkg::UsbNumW'(crystal_i);

  always_comb begin
    s2_d.main_lane.acc = pbcc_pkg::DivW'(main_num >> s1_main_q.s);
    s2_d.main_lane.rem = '0;
    s2_d.main_lane.den = s1_main_q.den;
    s2_d.usb_lane.acc  = pbcc_pkg::DivW'(usb_num >> s1_usb_q.s);
    s2_d.usb_lane.rem  = '0;
    s2_d.usb_lane.den  = s1_usb_q.den;
    s2_d.sel           = s1_sel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_cq_q   <= cq_prod[pbcc_pkg::Div100Shift +: pbcc_pkg::CqW];
      s1_main_q <= pbcc_pkg::split_pll(main_word_i);
      s1_usb_q  <= pbcc_pkg::split_pll(usb_word_i);
      s1_sel_q  <= '{bus: bus_i, cam: cam_i};
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

// File: design/pbcc_div_stage.sv
// one pipeline stage of the dual restoring divider
`timescale 1ns / 1ps

module pbcc_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pbcc_pkg::div_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pbcc_pkg::div_t  data_o
);

  logic           valid_q;
  pbcc_pkg::div_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.main_lane = pbcc_pkg::div_steps(data_i.main_lane);
    data_d.usb_lane  = pbcc_pkg::div_steps(data_i.usb_lane);
    data_d.sel       = data_i.sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/pbcc_post.sv
// fclk scaling, divide by three and clock selection stages
`timescale 1ns / 1ps

module pbcc_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  pbcc_pkg::div_t    data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output pbcc_pkg::clocks_t data_o
);

  logic                            a_ready, b_ready, c_ready;
  logic                            a_valid_q, b_valid_q, c_valid_q;
  logic [pbcc_pkg::ScaleProdW-1:0] scale_prod;
  logic [pbcc_pkg::ClkW-1:0]       usb_q_raw;
  logic [pbcc_pkg::ClkW-1:0]       a_fclk_q, a_uclk_q;
  pbcc_pkg::sel_t                  a_sel_q;
  logic [pbcc_pkg::Div3ProdW-1:0]  third_prod;
  logic [pbcc_pkg::ClkW-1:0]       b_fclk_q, b_third_q, b_uclk_q;
  pbcc_pkg::sel_t                  b_sel_q;
  pbcc_pkg::hclk_code_e            code;
  logic [pbcc_pkg::ClkW-1:0]       hclk;
  pbcc_pkg::clocks_t               c_d, c_q;

  assign c_ready = !c_valid_q || ready_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  // fclk = quotient * 100, wrapping at 32 bits
  assign scale_prod = pbcc_pkg::ScaleProdW'(data_i.main_lane.acc[pbcc_pkg::ClkW-1:0])
                    * pbcc_pkg::ScaleProdW'(pbcc_pkg::Scale100);
  assign usb_q_raw  = data_i.usb_lane.acc[pbcc_pkg::ClkW-1:0];

  assign third_prod = pbcc_pkg::Div3ProdW'(a_fclk_q) * pbcc_pkg::Div3ProdW'(pbcc_pkg::Div3Magic);

  assign code = pbcc_pkg::hclk_code_e'(b_sel_q.bus[pbcc_pkg::BusHclkLsb +: 2]);

  always_comb begin
    case (code)
      pbcc_pkg::HclkDiv1: hclk = b_fclk_q;
      pbcc_pkg::HclkDiv2: hclk = b_fclk_q >> 1;
      pbcc_pkg::HclkDiv4: hclk = b_sel_q.cam[pbcc_pkg::CamEighthBit] ? (b_fclk_q >> 3)
                                                                      : (b_fclk_q >> 2);
      pbcc_pkg::HclkDiv3: hclk = b_sel_q.cam[pbcc_pkg::CamSixthBit] ? (b_third_q >> 1)
                                                                     : b_third_q;
      default:            hclk = b_fclk_q;
    endcase
    c_d.core   = b_fclk_q;
    c_d.bus    = hclk;
    c_d.periph = b_sel_q.bus[pbcc_pkg::BusPclkHalfBit] ? (hclk >> 1) : hclk;
    c_d.cpu    = b_sel_q.cam[pbcc_pkg::CamCpuHclkBit] ? hclk : b_fclk_q;
    c_d.usb    = b_uclk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_fclk_q <= scale_prod[pbcc_pkg::ClkW-1:0];
      a_uclk_q <= data_i.sel.bus[pbcc_pkg::BusUsbHalfBit] ? (usb_q_raw >> 1) : usb_q_raw;
      a_sel_q  <= data_i.sel;
    end
    if (b_ready && a_valid_q) begin
      b_fclk_q  <= a_fclk_q;
      b_third_q <= pbcc_pkg::ClkW'(third_prod >> pbcc_pkg::Div3Shift);
      b_uclk_q  <= a_uclk_q;
      b_sel_q   <= a_sel_q;
    end
    if (c_ready && b_valid_q) begin
      c_q <= c_d;
    end
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_q;

endmodule

// File: bench/tb_top.sv
// self-checking testbench of the pll bus clock calculator: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [pbcc_pkg::CrystalW-1:0] xtal;
    logic [pbcc_pkg::PllW-1:0]     main_w;
    logic [pbcc_pkg::PllW-1:0]     usb_w;
    logic [pbcc_pkg::BusW-1:0]     bus_w;
    logic [pbcc_pkg::CamW-1:0]     cam_w;
    logic                          known;
    pbcc_pkg::clocks_t             want;
  } stim_row_t;

  localparam int unsigned NumRows       = 24;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 235;
  localparam int unsigned HoldAfter     = 400;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned TailCycles    = 20;

  localparam stim_row_t DirRows [NumRows] = '{
    '{24'd12000000, 20'h00000, 20'h00000, 4'h0, 8'h00, 1'b1,
      '{32'd96000000, 32'd96000000, 32'd96000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'hF, 8'hFF, 1'b1,
      '{32'd96000000, 32'd16000000, 32'd8000000, 32'd16000000, 32'd24000000}},
    '{24'd12000000, 20'hFFFFF, 20'hFFFFF, 4'h0, 8'h00, 1'b1,
      '{32'd12138400, 32'd12138400, 32'd12138400, 32'd12138400, 32'd6069230}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h2, 8'h00, 1'b1,
      '{32'd96000000, 32'd48000000, 32'd48000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h4, 8'h00, 1'b1,
      '{32'd96000000, 32'd24000000, 32'd24000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h4, 8'h02, 1'b1,
      '{32'd96000000, 32'd12000000, 32'd12000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h6, 8'h00, 1'b1,
      '{32'd96000000, 32'd32000000, 32'd32000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h6, 8'h01, 1'b1,
      '{32'd96000000, 32'd16000000, 32'd16000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h1, 8'h00, 1'b1,
      '{32'd96000000, 32'd96000000, 32'd48000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h8, 8'h00, 1'b1,
      '{32'd96000000, 32'd96000000, 32'd96000000, 32'd96000000, 32'd24000000}},
    '{24'd12000000, 20'h00000, 20'h00000, 4'h2, 8'h10, 1'b1,
      '{32'd96000000, 32'd48000000, 32'd48000000, 32'd48000000, 32'd48000000}},
    '{24'd12000000, 20'h00C0C, 20'h00C0C, 4'h0, 8'hEC, 1'b1,
      '{32'd96000000, 32'd96000000, 32'd96000000, 32'd96000000, 32'd48000000}},
    '{24'd12000000, 20'hFF000, 20'hFF000, 4'h0, 8'h00, 1'b1,
      '{32'd3156000000, 32'd3156000000, 32'd3156000000, 32'd3156000000, 32'd1578000000}},
    '{24'd12000000, 20'h00003, 20'h00003, 4'h0, 8'h00, 1'b1,
      '{32'd12000000, 32'd12000000, 32'd12000000, 32'd12000000, 32'd6000000}},
    '{24'd12000000, 20'h003F0, 20'h003F0, 4'h0, 8'h00, 1'b0, '0},
    '{24'd12000000, 20'h5A3C1, 20'hA5C32, 4'hB, 8'h13, 1'b0, '0},
    '{24'hFFFFFF,   20'hFF000, 20'hFF000, 4'h0, 8'h00, 1'b0, '0},
    '{24'hFFFFFF,   20'hFF000, 20'hFF000, 4'hF, 8'hFF, 1'b0, '0},
    '{24'hFFFFFF,   20'h00000, 20'h00000, 4'h6, 8'h12, 1'b0, '0},
    '{24'd0,        20'hFFFFF, 20'hFFFFF, 4'h0, 8'h00, 1'b1, '0},
    '{24'd0,        20'h00000, 20'h00000, 4'hF, 8'hFF, 1'b1, '0},
    '{24'd99,       20'hFF000, 20'hFF000, 4'h0, 8'h00, 1'b1,
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd13018}},
    '{24'd16000000, 20'hFF000, 20'h00000, 4'h0, 8'h00, 1'b1,
      '{32'd4208000000, 32'd4208000000, 32'd4208000000, 32'd4208000000, 32'd64000000}},
    '{24'd16000000, 20'hFFFFF, 20'hFFFFF, 4'h6, 8'h01, 1'b0, '0}
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pbcc_pkg::CrystalW-1:0] cfg_data_i;

  pbcc_in_if  in_if ();
  pbcc_out_if out_if ();

  pll_bus_clock_calculator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  logic [pbcc_pkg::CrystalW-1:0] crystal_model;
  pbcc_pkg::clocks_t             expected_clocks [$];
  logic                          want_known;
  pbcc_pkg::clocks_t             want_typed;
  logic                          steady;
  int unsigned                   inputs_taken;
  int unsigned                   err_count;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5000000;
    $display("** pll_bus_clock_calculator: FAILED **");
    $finish;
  end

  function automatic pbcc_pkg::clocks_t calc_clocks(logic [pbcc_pkg::CrystalW-1:0] xtal,
                                                    logic [pbcc_pkg::PllW-1:0] main_w,
                                                    logic [pbcc_pkg::PllW-1:0] usb_w,
                                                    logic [pbcc_pkg::BusW-1:0] bus_w,
                                                    logic [pbcc_pkg::CamW-1:0] cam_w);
    longint unsigned           m, p, s, num, den, xt;
    logic [pbcc_pkg::ClkW-1:0] fclk, hclk, upll;
    pbcc_pkg::hclk_code_e      code;
    pbcc_pkg::clocks_t         c;
    xt   = longint'(xtal);
    m    = longint'(main_w[19:12]);
    p    = longint'(main_w[9:4]);
    s    = longint'(main_w[1:0]);
    num  = (m + 8) * (xt / 100) * 2;
    den  = (p + 2) << s;
    fclk = pbcc_pkg::ClkW'((num / den) * 100);
    m    = longint'(usb_w[19:12]);
    p    = longint'(usb_w[9:4]);
    s    = longint'(usb_w[1:0]);
    num  = (m + 8) * xt;
    den  = (p + 2) << s;
    upll = pbcc_pkg::ClkW'(num / den);
    code = pbcc_pkg::hclk_code_e'(bus_w[pbcc_pkg::BusHclkLsb +: 2]);
    case (code)
      pbcc_pkg::HclkDiv1: hclk = fclk;
      pbcc_pkg::HclkDiv2: hclk = fclk >> 1;
      pbcc_pkg::HclkDiv4: hclk = cam_w[pbcc_pkg::CamEighthBit] ? (fclk >> 3) : (fclk >> 2);
      default:            hclk = cam_w[pbcc_pkg::CamSixthBit] ? (fclk / 6) : (fclk / 3);
    endcase
    c.core   = fclk;
    c.bus    = hclk;
    c.periph = bus_w[pbcc_pkg::BusPclkHalfBit] ? (hclk >> 1) : hclk;
    c.cpu    = cam_w[pbcc_pkg::CamCpuHclkBit] ? hclk : fclk;
    c.usb    = bus_w[pbcc_pkg::BusUsbHalfBit] ? (upll >> 1) : upll;
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [pbcc_pkg::PllW-1:0] rand_pll_word();
    logic [pbcc_pkg::PllW-1:0] w;
    w = pbcc_pkg::PllW'($urandom);
    case ($urandom_range(0, 7))
      0: w[19:12] = 8'hFF;
      1: w[19:12] = 8'h00;
      2: w[9:4] = 6'h3F;
      3: w[9:4] = 6'h00;
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crystal_model <= pbcc_pkg::CrystalReset;
    end else if (cfg_we_i) begin
      crystal_model <= cfg_data_i;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      inputs_taken++;
      if (want_known) begin
        expected_clocks.push_back(want_typed);
      end else begin
        expected_clocks.push_back(calc_clocks(crystal_model, in_if.main_pll_word,
                                              in_if.usb_pll_word, in_if.bus_divider_word,
                                              in_if.camera_divider_high));
      end
    end
  end

  task automatic check_field(string name, logic [pbcc_pkg::ClkW-1:0] want,
                             logic [pbcc_pkg::ClkW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    pbcc_pkg::clocks_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_clocks.size() == 0) begin
        $error("result transaction with no input pending");
        err_count++;
      end else begin
        want = expected_clocks.pop_front();
        check_field("core_clock_hz", want.core, out_if.core_clock_hz);
        check_field("bus_clock_hz", want.bus, out_if.bus_clock_hz);
        check_field("peripheral_clock_hz", want.periph, out_if.peripheral_clock_hz);
        check_field("cpu_clock_hz", want.cpu, out_if.cpu_clock_hz);
        check_field("usb_clock_hz", want.usb, out_if.usb_clock_hz);
      end
    end
  end

  // result side: random stalls (ready held high in the steady phase), one long hold-off after HoldAfter inputs
  initial begin
    bit          held;
    logic        level;
    int unsigned n;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && inputs_taken >= HoldAfter) begin
        held  = 1'b1;
        level = 1'b0;
        n     = HoldCycles;
      end else if (steady) begin
        level = 1'b1;
        n     = 20;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b0;
        n     = pick_gap() + 1;
      end else begin
        level = 1'b1;
        n     = $urandom_range(1, 20);
      end
      out_if.ready <= level;
      repeat (n) @(negedge clk_i);
    end
  end

  task automatic send_query(logic [pbcc_pkg::PllW-1:0] main_w, logic [pbcc_pkg::PllW-1:0] usb_w,
                            logic [pbcc_pkg::BusW-1:0] bus_w, logic [pbcc_pkg::CamW-1:0] cam_w,
                            logic known, pbcc_pkg::clocks_t want);
    int unsigned gap;
    in_if.valid               <= 1'b1;
    in_if.main_pll_word       <= main_w;
    in_if.usb_pll_word        <= usb_w;
    in_if.bus_divider_word    <= bus_w;
    in_if.camera_divider_high <= cam_w;
    want_known                <= known;
    want_typed                <= want;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_clocks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_crystal(logic [pbcc_pkg::CrystalW-1:0] xtal);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= xtal;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [pbcc_pkg::CrystalW-1:0] cur_xtal;
    logic [pbcc_pkg::CrystalW-1:0] next_xtal;
    rst_ni                    = 1'b0;
    cfg_we_i                  = 1'b0;
    cfg_data_i                = '0;
    in_if.valid               = 1'b0;
    in_if.main_pll_word       = '0;
    in_if.usb_pll_word        = '0;
    in_if.bus_divider_word    = '0;
    in_if.camera_divider_high = '0;
    want_known                = 1'b0;
    want_typed                = '0;
    steady                    = 1'b0;
    inputs_taken              = 0;
    err_count                 = 0;
    cur_xtal                  = pbcc_pkg::CrystalReset;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].xtal != cur_xtal) begin
        cur_xtal = DirRows[i].xtal;
        set_crystal(cur_xtal);
      end
      send_query(DirRows[i].main_w, DirRows[i].usb_w, DirRows[i].bus_w, DirRows[i].cam_w,
                 DirRows[i].known, DirRows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       next_xtal = 24'd12000000;
        1:       next_xtal = 24'hFFFFFF;
        2:       next_xtal = 24'd0;
        3:       next_xtal = pbcc_pkg::CrystalW'($urandom_range(1, 16000000));
        4:       next_xtal = pbcc_pkg::CrystalW'($urandom);
        5:       next_xtal = 24'd16000000;
        6:       next_xtal = 24'd100;
        default: next_xtal = pbcc_pkg::CrystalW'($urandom_range(8000000, 16000000));
      endcase
      set_crystal(next_xtal);
      steady = (ph == 5);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        send_query(rand_pll_word(), rand_pll_word(), pbcc_pkg::BusW'($urandom),
                   pbcc_pkg::CamW'($urandom), 1'b0, '0);
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("** pll_bus_clock_calculator: PASSED **");
    end else begin
      $display("** pll_bus_clock_calculator: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/pbcc_pkg.sv
design/pbcc_intf.sv
design/pbcc_prep.sv
design/pbcc_div_stage.sv
design/pbcc_post.sv
design/pll_bus_clock_calculator.sv
bench/tb_top.sv
